// File: rtl/magnetometer_frame_heading_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the magnetometer frame heading block
// Implication and next-cycle implication checks on one clock and reset.
// Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef MAGNETOMETER_FRAME_HEADING_MACROS_SVH
`define MAGNETOMETER_FRAME_HEADING_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MFH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define MFH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define MFH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MFH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/mfh_pkg.sv
// ---------------------------------------------------------------------------
// mfh_pkg
// Shared constants, types and the arctangent table of the frame heading block.
// ---------------------------------------------------------------------------
package mfh_pkg;

	// frame layout
	localparam int FRAME_LENGTH = 28;
	localparam int POS_W        = $clog2(FRAME_LENGTH);
	localparam int FIELD_CHARS  = 5;
	localparam int FIELD_START [3] = '{4, 12, 20};  // frame order X, Z, Y

	// field widths
	localparam int MAG_W = 17;
	localparam int VAL_W = 18;
	localparam int DEG_W = 9;

	// CORDIC sizing
	localparam int ANGLE_ITERATIONS = 16;
	localparam int ITER_COUNT = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;
	localparam int ITER_W     = $clog2(ITER_COUNT);
	localparam int FRAC       = 16;
	localparam int CW         = 38;  // scaled x/y datapath
	localparam int ZW         = 26;  // angle accumulator, degrees with FRAC bits

	// exact angles
	localparam logic signed [ZW-1:0] DEG_45  = ZW'(45 << FRAC);
	localparam logic signed [ZW-1:0] DEG_90  = ZW'(90 << FRAC);
	localparam logic signed [ZW-1:0] DEG_135 = ZW'(135 << FRAC);
	localparam logic signed [ZW-1:0] DEG_180 = ZW'(180 << FRAC);
	localparam logic signed [ZW-1:0] DEG_225 = ZW'(225 << FRAC);
	localparam logic signed [ZW-1:0] DEG_270 = ZW'(270 << FRAC);
	localparam logic signed [ZW-1:0] DEG_315 = ZW'(315 << FRAC);
	localparam logic signed [ZW-1:0] DEG_360 = ZW'(360 << FRAC);

	// configuration
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK    = 1'b1;
	localparam logic [CFG_W-1:0] TIMEOUT_RESET   = 16'd50;

	// input item kinds
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// characters
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// angle runs, in the order they are computed
	localparam logic [1:0] RUN_HEADING = 2'd0;
	localparam logic [1:0] RUN_XZ      = 2'd1;
	localparam logic [1:0] RUN_YZ      = 2'd2;

	typedef enum logic [1:0] {
		PH_BLANK,
		PH_SIGN,
		PH_DIGIT,
		PH_STOP
	} parse_phase_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             minus;
		parse_phase_t     phase;
	} parse_t;

	localparam parse_t PARSE_CLEAR = '{mag: '0, minus: 1'b0, phase: PH_BLANK};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_PUSH
	} top_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ITER,
		CS_FIN,
		CS_OUT
	} cordic_state_t;

	typedef struct packed {
		logic                    start;
		logic signed [VAL_W-1:0] y;
		logic signed [VAL_W-1:0] x;
	} angle_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [ZW-1:0] angle;
	} angle_rsp_t;

	// atan(2^-i) in degrees, FRAC fraction bits, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
		logic signed [ZW-1:0] v;
		unique case (i)
			5'd0:  v = 26'sd2949120;
			5'd1:  v = 26'sd1740967;
			5'd2:  v = 26'sd919879;
			5'd3:  v = 26'sd466945;
			5'd4:  v = 26'sd234379;
			5'd5:  v = 26'sd117304;
			5'd6:  v = 26'sd58666;
			5'd7:  v = 26'sd29335;
			5'd8:  v = 26'sd14668;
			5'd9:  v = 26'sd7334;
			5'd10: v = 26'sd3667;
			5'd11: v = 26'sd1833;
			5'd12: v = 26'sd917;
			5'd13: v = 26'sd458;
			5'd14: v = 26'sd229;
			5'd15: v = 26'sd115;
			5'd16: v = 26'sd57;
			5'd17: v = 26'sd29;
			5'd18: v = 26'sd14;
			5'd19: v = 26'sd7;
			5'd20: v = 26'sd4;
			5'd21: v = 26'sd2;
			5'd22: v = 26'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/mfh_cordic.sv
// ---------------------------------------------------------------------------
// mfh_cordic
// Iterative vectoring CORDIC atan2: one rotation per cycle on a shared
// add/shift datapath; exact directions bypass the iterations.
// ---------------------------------------------------------------------------
module mfh_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  mfh_pkg::angle_req_t req,
	output mfh_pkg::angle_rsp_t rsp
);

	mfh_pkg::cordic_state_t state_q, state_d;

	logic signed [mfh_pkg::CW-1:0] x_q, y_q;
	logic signed [mfh_pkg::CW-1:0] x_sh, y_sh, x_in, y_in;
	logic signed [mfh_pkg::ZW-1:0] z_q, ang_q, z_exact, step_angle;
	logic [mfh_pkg::ITER_W-1:0]    i_q;
	logic [mfh_pkg::VAL_W:0]       ax, ay;
	logic                          exact;
	logic                          last_iter;

	// operand classification for the exact directions
	always_comb begin
		ax = req.x[mfh_pkg::VAL_W-1] ? -{req.x[mfh_pkg::VAL_W-1], req.x}
			: {req.x[mfh_pkg::VAL_W-1], req.x};
		ay = req.y[mfh_pkg::VAL_W-1] ? -{req.y[mfh_pkg::VAL_W-1], req.y}
			: {req.y[mfh_pkg::VAL_W-1], req.y};
		exact = (req.y == '0) || (req.x == '0) || (ax == ay);
		priority if (req.y == '0) begin
			z_exact = req.x[mfh_pkg::VAL_W-1] ? mfh_pkg::DEG_180 : '0;
		end else if (req.x == '0) begin
			z_exact = req.y[mfh_pkg::VAL_W-1] ? mfh_pkg::DEG_270 : mfh_pkg::DEG_90;
		end else if (!req.x[mfh_pkg::VAL_W-1]) begin
			z_exact = req.y[mfh_pkg::VAL_W-1] ? mfh_pkg::DEG_315 : mfh_pkg::DEG_45;
		end else begin
			z_exact = req.y[mfh_pkg::VAL_W-1] ? mfh_pkg::DEG_225 : mfh_pkg::DEG_135;
		end
	end

	// readings scaled by 2^FRAC
	assign x_in = {{(mfh_pkg::CW - mfh_pkg::VAL_W - mfh_pkg::FRAC){req.x[mfh_pkg::VAL_W-1]}},
		req.x, {mfh_pkg::FRAC{1'b0}}};
	assign y_in = {{(mfh_pkg::CW - mfh_pkg::VAL_W - mfh_pkg::FRAC){req.y[mfh_pkg::VAL_W-1]}},
		req.y, {mfh_pkg::FRAC{1'b0}}};

	// shared rotation unit: floor shifts and table step
	assign x_sh       = x_q >>> i_q;
	assign y_sh       = y_q >>> i_q;
	assign step_angle = mfh_pkg::atan_entry(5'(i_q));
	assign last_iter  = (i_q == mfh_pkg::ITER_W'(mfh_pkg::ITER_COUNT - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfh_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and response
	always_comb begin
		state_d   = state_q;
		rsp.done  = 1'b0;
		rsp.angle = ang_q;
		unique case (state_q)
			mfh_pkg::CS_IDLE: begin
				if (req.start) begin
					state_d = exact ? mfh_pkg::CS_FIN : mfh_pkg::CS_ITER;
				end
			end
			mfh_pkg::CS_ITER: begin
				if (last_iter) begin
					state_d = mfh_pkg::CS_FIN;
				end
			end
			mfh_pkg::CS_FIN: begin
				state_d = mfh_pkg::CS_OUT;
			end
			mfh_pkg::CS_OUT: begin
				rsp.done = 1'b1;
				state_d  = mfh_pkg::CS_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			mfh_pkg::CS_IDLE: begin
				if (req.start) begin
					i_q <= '0;
					if (exact) begin
						z_q <= z_exact;
					end else if (req.x[mfh_pkg::VAL_W-1]) begin
						// fold into the right half plane
						x_q <= -x_in;
						y_q <= -y_in;
						z_q <= mfh_pkg::DEG_180;
					end else begin
						x_q <= x_in;
						y_q <= y_in;
						z_q <= '0;
					end
				end
			end
			mfh_pkg::CS_ITER: begin
				i_q <= i_q + 1'b1;
				if (!y_q[mfh_pkg::CW-1]) begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + step_angle;
				end else begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - step_angle;
				end
			end
			mfh_pkg::CS_FIN: begin
				ang_q <= z_q[mfh_pkg::ZW-1] ? z_q + mfh_pkg::DEG_360 : z_q;
			end
			mfh_pkg::CS_OUT: begin
			end
		endcase
	end

endmodule

// File: rtl/magnetometer_frame_heading.sv
// ---------------------------------------------------------------------------
// magnetometer_frame_heading
// Serial frame collector, decimal field parser and heading/tilt calculator.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per received
//   byte (command 0) or per time tick (command 1). Output channel
//   (out_valid/out_stall) carries at most one result per input transaction.
//   A byte that does not close the 28-byte frame gives no result and is
//   taken without raising in_stall. A closing byte of a non-'S' frame, or a
//   timeout tick while link_enabled is 1, moves to the push state, from which
//   out_valid is registered once the output register is free.
//   A closing byte of an 'S' frame runs three atan2 passes through one shared
//   CORDIC unit, an exact direction skipping the iterations; in_stall is held
//   high from acceptance until the result is handed to the output register.
//   If the receiver stalls, the finished result waits in the output register;
//   further transactions are taken until one gives a result, which is held in
//   a staging register, after which in_stall stays high until the output
//   register is free. Reset clears the partial frame, arms the timer and
//   loads timeout_ticks 50 and link_enabled 1. cfg_we writes are registered.
// ---------------------------------------------------------------------------
`include "magnetometer_frame_heading_macros.svh"

module magnetometer_frame_heading (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 command,
	input  logic [7:0]                           rx_byte,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 send_request,
	output logic                                 frame_done,
	output logic                                 frame_ok,
	output logic [mfh_pkg::DEG_W-1:0]            heading_deg,
	output logic [mfh_pkg::DEG_W-1:0]            tilt_xz_deg,
	output logic [mfh_pkg::DEG_W-1:0]            tilt_yz_deg,
	output logic signed [mfh_pkg::VAL_W-1:0]     field_x,
	output logic signed [mfh_pkg::VAL_W-1:0]     field_y,
	output logic signed [mfh_pkg::VAL_W-1:0]     field_z,
	// configuration
	input  logic                                 cfg_we,
	input  logic [mfh_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mfh_pkg::CFG_W-1:0]            cfg_data
);

	mfh_pkg::top_state_t state_q, state_d;

	// frame and timer state
	logic [mfh_pkg::POS_W-1:0] pos_q;
	logic                      start_q;
	mfh_pkg::parse_t           fld_q [3];
	logic [mfh_pkg::CFG_W-1:0] silence_q, timeout_q;
	logic                      armed_q, link_q;
	logic [1:0]                run_q;
	logic                      out_valid_q;

	// staged result
	logic                            res_send_q, res_done_q, res_ok_q;
	logic [mfh_pkg::DEG_W-1:0]       res_head_q, res_xz_q, res_yz_q;
	logic signed [mfh_pkg::VAL_W-1:0] res_x_q, res_y_q, res_z_q;

	// output register
	logic                            out_send_q, out_done_q, out_ok_q;
	logic [mfh_pkg::DEG_W-1:0]       out_head_q, out_xz_q, out_yz_q;
	logic signed [mfh_pkg::VAL_W-1:0] out_x_q, out_y_q, out_z_q;

	logic                            in_acc, is_tick, close, out_free;
	logic [mfh_pkg::CFG_W-1:0]       tick_inc, limit;
	logic                            tick_fire;
	logic [2:0]                      fsel;
	logic signed [mfh_pkg::VAL_W-1:0] val [3];
	logic signed [mfh_pkg::ZW-1:0]   offset, rdiff, rwrap;
	logic [mfh_pkg::DEG_W-1:0]       run_deg;

	mfh_pkg::angle_req_t req;
	mfh_pkg::angle_rsp_t rsp;

	// one character through the strtol-style parser
	function automatic mfh_pkg::parse_t parse_step(input mfh_pkg::parse_t cur,
		input logic [7:0] c);
		mfh_pkg::parse_t        nxt;
		logic                   blank, digit;
		logic [mfh_pkg::MAG_W-1:0] dv;
		nxt   = cur;
		blank = (c == mfh_pkg::CH_SPACE) || (c >= mfh_pkg::CH_TAB && c <= mfh_pkg::CH_CR);
		digit = (c >= mfh_pkg::CH_0) && (c <= mfh_pkg::CH_9);
		dv    = mfh_pkg::MAG_W'(c[3:0]);
		unique case (cur.phase)
			mfh_pkg::PH_BLANK: begin
				priority if (blank) begin
					nxt.phase = mfh_pkg::PH_BLANK;
				end else if (c == mfh_pkg::CH_PLUS || c == mfh_pkg::CH_MINUS) begin
					nxt.minus = (c == mfh_pkg::CH_MINUS);
					nxt.phase = mfh_pkg::PH_SIGN;
				end else if (digit) begin
					nxt.mag   = dv;
					nxt.phase = mfh_pkg::PH_DIGIT;
				end else begin
					nxt.phase = mfh_pkg::PH_STOP;
				end
			end
			mfh_pkg::PH_SIGN: begin
				if (digit) begin
					nxt.mag   = dv;
					nxt.phase = mfh_pkg::PH_DIGIT;
				end else begin
					// lone sign reads as zero
					nxt.minus = 1'b0;
					nxt.phase = mfh_pkg::PH_STOP;
				end
			end
			mfh_pkg::PH_DIGIT: begin
				if (digit) begin
					nxt.mag = (cur.mag << 3) + (cur.mag << 1) + dv;
				end else begin
					nxt.phase = mfh_pkg::PH_STOP;
				end
			end
			mfh_pkg::PH_STOP: begin
			end
		endcase
		return nxt;
	endfunction

	// handshake and frame position decode
	assign in_stall = (state_q != mfh_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign is_tick  = (command == mfh_pkg::CMD_TICK);
	assign close    = (pos_q == mfh_pkg::POS_W'(mfh_pkg::FRAME_LENGTH - 1));
	assign out_free = !out_valid_q || !out_stall;

	// silence timer
	assign tick_inc  = (silence_q == '1) ? silence_q : silence_q + 1'b1;
	assign limit     = (timeout_q == '0) ? mfh_pkg::CFG_W'(1) : timeout_q;
	assign tick_fire = armed_q && (tick_inc >= limit);

	// field windows and signed readings
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fsel[k] = (pos_q >= mfh_pkg::POS_W'(mfh_pkg::FIELD_START[k])) &&
				(pos_q <= mfh_pkg::POS_W'(mfh_pkg::FIELD_START[k] + mfh_pkg::FIELD_CHARS - 1));
			val[k]  = fld_q[k].minus ? -{1'b0, fld_q[k].mag} : {1'b0, fld_q[k].mag};
		end
	end

	// operand select for the current angle run
	always_comb begin
		req.start = (state_q == mfh_pkg::ST_START);
		unique case (run_q)
			mfh_pkg::RUN_HEADING: begin
				req.y  = res_x_q;
				req.x  = res_y_q;
				offset = mfh_pkg::DEG_270;
			end
			mfh_pkg::RUN_XZ: begin
				req.y  = res_x_q;
				req.x  = res_z_q;
				offset = mfh_pkg::DEG_180;
			end
			default: begin
				req.y  = res_y_q;
				req.x  = res_z_q;
				offset = mfh_pkg::DEG_180;
			end
		endcase
		rdiff   = offset - rsp.angle;
		rwrap   = rdiff[mfh_pkg::ZW-1] ? rdiff + mfh_pkg::DEG_360 : rdiff;
		run_deg = rwrap[mfh_pkg::FRAC+mfh_pkg::DEG_W-1:mfh_pkg::FRAC];
	end

	mfh_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfh_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (is_tick) begin
						if (tick_fire && link_q) begin
							state_d = mfh_pkg::ST_PUSH;
						end
					end else if (close) begin
						state_d = start_q ? mfh_pkg::ST_START : mfh_pkg::ST_PUSH;
					end
				end
			end
			mfh_pkg::ST_START: begin
				state_d = mfh_pkg::ST_WAIT;
			end
			mfh_pkg::ST_WAIT: begin
				if (rsp.done) begin
					state_d = (run_q == mfh_pkg::RUN_YZ) ? mfh_pkg::ST_PUSH
						: mfh_pkg::ST_START;
				end
			end
			mfh_pkg::ST_PUSH: begin
				if (out_free) begin
					state_d = mfh_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// frame, timer, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			start_q     <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				fld_q[k] <= mfh_pkg::PARSE_CLEAR;
			end
			silence_q   <= '0;
			armed_q     <= 1'b1;
			timeout_q   <= mfh_pkg::TIMEOUT_RESET;
			link_q      <= 1'b1;
			run_q       <= mfh_pkg::RUN_HEADING;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mfh_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
					mfh_pkg::CFG_LINK:    link_q    <= cfg_data[0];
				endcase
			end

			if (in_acc) begin
				if (is_tick) begin
					if (armed_q) begin
						if (tick_fire) begin
							// silence timeout: drop the partial frame
							pos_q     <= '0;
							start_q   <= 1'b0;
							for (int k = 0; k < 3; k++) begin
								fld_q[k] <= mfh_pkg::PARSE_CLEAR;
							end
							silence_q <= '0;
							armed_q   <= link_q;
						end else begin
							silence_q <= tick_inc;
						end
					end
				end else begin
					silence_q <= '0;
					armed_q   <= 1'b1;
					if (close) begin
						pos_q   <= '0;
						start_q <= 1'b0;
						for (int k = 0; k < 3; k++) begin
							fld_q[k] <= mfh_pkg::PARSE_CLEAR;
						end
						run_q   <= mfh_pkg::RUN_HEADING;
					end else begin
						pos_q <= pos_q + 1'b1;
						if (pos_q == '0) begin
							start_q <= (rx_byte == mfh_pkg::CH_S);
						end
						for (int k = 0; k < 3; k++) begin
							if (fsel[k]) begin
								fld_q[k] <= parse_step(fld_q[k], rx_byte);
							end
						end
					end
				end
			end

			if (state_q == mfh_pkg::ST_WAIT && rsp.done) begin
				run_q <= run_q + 1'b1;
			end

			if (state_q == mfh_pkg::ST_PUSH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// staged result and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (is_tick) begin
				if (tick_fire && link_q) begin
					res_send_q <= 1'b1;
					res_done_q <= 1'b0;
					res_ok_q   <= 1'b0;
					res_head_q <= '0;
					res_xz_q   <= '0;
					res_yz_q   <= '0;
					res_x_q    <= '0;
					res_y_q    <= '0;
					res_z_q    <= '0;
				end
			end else if (close) begin
				res_send_q <= link_q;
				res_done_q <= 1'b1;
				res_ok_q   <= start_q;
				res_head_q <= '0;
				res_xz_q   <= '0;
				res_yz_q   <= '0;
				res_x_q    <= start_q ? val[0] : '0;
				res_y_q    <= start_q ? val[2] : '0;
				res_z_q    <= start_q ? val[1] : '0;
			end
		end

		// angle run finished
		if (state_q == mfh_pkg::ST_WAIT && rsp.done) begin
			unique case (run_q)
				mfh_pkg::RUN_HEADING: res_head_q <= run_deg;
				mfh_pkg::RUN_XZ:      res_xz_q   <= run_deg;
				default:              res_yz_q   <= run_deg;
			endcase
		end

		// hand the staged result to the output register
		if (state_q == mfh_pkg::ST_PUSH && out_free) begin
			out_send_q <= res_send_q;
			out_done_q <= res_done_q;
			out_ok_q   <= res_ok_q;
			out_head_q <= res_head_q;
			out_xz_q   <= res_xz_q;
			out_yz_q   <= res_yz_q;
			out_x_q    <= res_x_q;
			out_y_q    <= res_y_q;
			out_z_q    <= res_z_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign send_request = out_send_q;
	assign frame_done   = out_done_q;
	assign frame_ok     = out_ok_q;
	assign heading_deg  = out_head_q;
	assign tilt_xz_deg  = out_xz_q;
	assign tilt_yz_deg  = out_yz_q;
	assign field_x      = out_x_q;
	assign field_y      = out_y_q;
	assign field_z      = out_z_q;

	// checks
	`MFH_ASSERT_IMP(a_timeout_result, clk, arst_n, out_valid_q && !out_done_q, out_send_q && !out_ok_q && out_head_q == '0 && out_x_q == '0)
	`MFH_ASSERT_IMP(a_angle_range, clk, arst_n, out_valid_q && out_ok_q, out_head_q < 9'd360 && out_xz_q < 9'd360 && out_yz_q < 9'd360)
	`MFH_ASSERT_IMP(a_done_in_wait, clk, arst_n, rsp.done, state_q == mfh_pkg::ST_WAIT)
	`MFH_ASSERT_NXT(a_close_busy, clk, arst_n, in_acc && !is_tick && close, state_q != mfh_pkg::ST_IDLE)

endmodule

// File: tb/sv/mfh_heading_checker.sv
// ---------------------------------------------------------------------------
// Frame heading checker
// Watches both channels and the register port of the frame heading block,
// keeps its own copy of the frame parser, timer and CORDIC angle math, and
// compares every result transaction field by field with the oldest one due.
// ---------------------------------------------------------------------------
module mfh_heading_checker
	import mfh_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        command,
	input  logic [7:0]                  rx_byte,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        send_request,
	input  logic                        frame_done,
	input  logic                        frame_ok,
	input  logic [DEG_W-1:0]            heading_deg,
	input  logic [DEG_W-1:0]            tilt_xz_deg,
	input  logic [DEG_W-1:0]            tilt_yz_deg,
	input  logic signed [VAL_W-1:0]     field_x,
	input  logic signed [VAL_W-1:0]     field_y,
	input  logic signed [VAL_W-1:0]     field_z,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data,
	output int                          mismatches,
	output int                          results_due
);

	localparam longint ONE_DEG = 64'sd65536;
	localparam int     REPORT_LIMIT = 10;

	// atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
	localparam longint ATAN_DEG [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct packed {
		logic                    send_request;
		logic                    frame_done;
		logic                    frame_ok;
		logic [DEG_W-1:0]        heading;
		logic [DEG_W-1:0]        tilt_xz;
		logic [DEG_W-1:0]        tilt_yz;
		logic signed [VAL_W-1:0] fx;
		logic signed [VAL_W-1:0] fy;
		logic signed [VAL_W-1:0] fz;
	} heading_rec_t;

	// predicted block state; field entries in frame order X, Z, Y
	logic [CFG_W-1:0]   timeout_reg;
	logic               link_reg;
	logic [4:0]         byte_pos;
	logic               start_seen;
	logic [MAG_W-1:0]   mag [3];
	logic               minus [3];
	parse_phase_t       phase [3];
	logic [15:0]        silence_cnt;
	logic               timer_armed;

	heading_rec_t       headings_due [$];
	int                 results_seen;

	function automatic void drop_frame();
		byte_pos = '0;
		start_seen = 1'b0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = '0;
			minus[k] = 1'b0;
			phase[k] = PH_BLANK;
		end
	endfunction

	// strtol-style digit collection, one character at a time
	function automatic void parse_char(input int k, input logic [7:0] c);
		logic blank;
		logic digit;
		blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		digit = (c >= CH_0) && (c <= CH_9);
		case (phase[k])
			PH_BLANK: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					minus[k] = (c == CH_MINUS);
					phase[k] = PH_SIGN;
				end else if (digit) begin
					mag[k] = MAG_W'(c - CH_0);
					phase[k] = PH_DIGIT;
				end else if (!blank) begin
					phase[k] = PH_STOP;
				end
			end
			PH_SIGN: begin
				if (digit) begin
					mag[k] = MAG_W'(c - CH_0);
					phase[k] = PH_DIGIT;
				end else begin
					minus[k] = 1'b0;
					phase[k] = PH_STOP;
				end
			end
			PH_DIGIT: begin
				if (digit)
					mag[k] = MAG_W'(mag[k] * 10 + (c - CH_0));
				else
					phase[k] = PH_STOP;
			end
			default: ;
		endcase
	endfunction

	// atan2(y, x) in degrees with FRAC fraction bits, in [0, 360)
	function automatic longint atan2_fix(input longint yv, input longint xv);
		longint ay, ax, base, zacc, nx, ny, a;
		ay = (yv < 0) ? -yv : yv;
		ax = (xv < 0) ? -xv : xv;
		base = 0;
		zacc = 0;
		if (yv == 0)
			return (xv < 0) ? 180 * ONE_DEG : 0;
		if (xv == 0)
			return (yv > 0) ? 90 * ONE_DEG : 270 * ONE_DEG;
		if (ax == ay) begin
			if (xv > 0)
				return (yv > 0) ? 45 * ONE_DEG : 315 * ONE_DEG;
			return (yv > 0) ? 135 * ONE_DEG : 225 * ONE_DEG;
		end
		xv = xv * ONE_DEG;
		yv = yv * ONE_DEG;
		// fold the left half-plane onto the right one
		if (xv < 0) begin
			xv = -xv;
			yv = -yv;
			base = 180 * ONE_DEG;
		end
		for (int i = 0; i < ITER_COUNT; i++) begin
			if (yv >= 0) begin
				nx = xv + (yv >>> i);
				ny = yv - (xv >>> i);
				zacc += ATAN_DEG[i];
			end else begin
				nx = xv - (yv >>> i);
				ny = yv + (xv >>> i);
				zacc -= ATAN_DEG[i];
			end
			xv = nx;
			yv = ny;
		end
		a = base + zacc;
		while (a < 0)
			a += 360 * ONE_DEG;
		while (a >= 360 * ONE_DEG)
			a -= 360 * ONE_DEG;
		return a;
	endfunction

	function automatic logic [DEG_W-1:0] wrap_deg(input longint offset_deg, input longint ang);
		longint r;
		r = offset_deg * ONE_DEG - ang;
		if (r < 0)
			r += 360 * ONE_DEG;
		return DEG_W'(r >>> FRAC);
	endfunction

	// advance the predicted state by one input transaction
	function automatic bit predict_heading(input logic cmd, input logic [7:0] c,
			output heading_rec_t rec);
		logic [16:0] limit;
		longint vals [3];
		rec = '0;
		if (cmd == CMD_TICK) begin
			limit = (timeout_reg == '0) ? 17'd1 : {1'b0, timeout_reg};
			if (!timer_armed)
				return 1'b0;
			if (silence_cnt != 16'hFFFF)
				silence_cnt++;
			if (silence_cnt < limit)
				return 1'b0;
			drop_frame();
			silence_cnt = '0;
			timer_armed = link_reg;
			rec.send_request = 1'b1;
			return link_reg;
		end

		silence_cnt = '0;
		timer_armed = 1'b1;
		if (byte_pos == 0)
			start_seen = (c == CH_S);
		for (int k = 0; k < 3; k++)
			if (byte_pos >= 4 + 8 * k && byte_pos < 4 + 8 * k + FIELD_CHARS)
				parse_char(k, c);
		byte_pos++;
		if (byte_pos < FRAME_LENGTH)
			return 1'b0;

		rec.send_request = link_reg;
		rec.frame_done = 1'b1;
		if (start_seen) begin
			for (int k = 0; k < 3; k++)
				vals[k] = minus[k] ? -longint'(mag[k]) : longint'(mag[k]);
			rec.frame_ok = 1'b1;
			rec.heading = wrap_deg(270, atan2_fix(vals[0], vals[2]));
			rec.tilt_xz = wrap_deg(180, atan2_fix(vals[0], vals[1]));
			rec.tilt_yz = wrap_deg(180, atan2_fix(vals[2], vals[1]));
			rec.fx = VAL_W'(vals[0]);
			rec.fz = VAL_W'(vals[1]);
			rec.fy = VAL_W'(vals[2]);
		end
		drop_frame();
		return 1'b1;
	endfunction

	function automatic void compare_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("result %0d: %s expected %0d, got %0d",
					results_seen, name, want, got);
		end
	endfunction

	// config tracking, result checking, then prediction of the new transaction
	always @(posedge clk or negedge arst_n) begin
		heading_rec_t want;
		heading_rec_t next_rec;
		if (!arst_n) begin
			timeout_reg = TIMEOUT_RESET;
			link_reg = 1'b1;
			drop_frame();
			silence_cnt = '0;
			timer_armed = 1'b1;
			headings_due.delete();
			results_seen = 0;
			mismatches = 0;
			results_due = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_TIMEOUT)
					timeout_reg = cfg_data;
				else if (cfg_index == CFG_LINK)
					link_reg = cfg_data[0];
			end

			if (out_valid && !out_stall) begin
				results_seen++;
				if (headings_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result %0d: transaction arrived with none expected",
							results_seen);
				end else begin
					want = headings_due.pop_front();
					compare_field("send_request", want.send_request, send_request);
					compare_field("frame_done", want.frame_done, frame_done);
					compare_field("frame_ok", want.frame_ok, frame_ok);
					compare_field("heading_deg", want.heading, heading_deg);
					compare_field("tilt_xz_deg", want.tilt_xz, tilt_xz_deg);
					compare_field("tilt_yz_deg", want.tilt_yz, tilt_yz_deg);
					compare_field("field_x", want.fx, field_x);
					compare_field("field_y", want.fy, field_y);
					compare_field("field_z", want.fz, field_z);
				end
			end

			if (in_valid && !in_stall)
				if (predict_heading(command, rx_byte, next_rec))
					headings_due.push_back(next_rec);

			results_due = headings_due.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// Frame heading testbench
// Feeds serial bytes and time ticks to the frame heading block: directed
// frames for number parsing, exact directions and timeouts, then random
// well-formed, broken and noisy traffic under several timeout and link
// settings, with bursty input and a randomly stalling receiver.
// ---------------------------------------------------------------------------
module tb;
	import mfh_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 400;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        command = CMD_BYTE;
	logic [7:0]                  rx_byte = 8'h00;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        send_request;
	logic                        frame_done;
	logic                        frame_ok;
	logic [DEG_W-1:0]            heading_deg;
	logic [DEG_W-1:0]            tilt_xz_deg;
	logic [DEG_W-1:0]            tilt_yz_deg;
	logic signed [VAL_W-1:0]     field_x;
	logic signed [VAL_W-1:0]     field_y;
	logic signed [VAL_W-1:0]     field_z;
	logic                        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = CFG_TIMEOUT;
	logic [CFG_W-1:0]            cfg_data = '0;

	int                          mismatches;
	int                          results_due;

	// stimulus bookkeeping
	int                          items_sent = 0;
	int                          burst_left = 0;
	bit                          gaps_on = 1'b1;
	int unsigned                 timeout_now = TIMEOUT_RESET;
	logic                        link_now = 1'b1;
	int                          hold_ask = 0;
	int                          cycle_count = 0;

	// receiver state
	int                          hold_done = 0;
	int                          hold_left = 0;
	int                          mode_left = 0;
	stall_mode_t                 stall_mode = STALL_NONE;

	magnetometer_frame_heading u_top (.*);

	mfh_heading_checker u_checker (.*);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** magnetometer_frame_heading: FAILED **");
			$finish;
		end
	end

	// receiver: random stall patterns, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_done != hold_ask) begin
			hold_done = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 300);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:   out_stall <= 1'b0;
				STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
				default:      out_stall <= ~out_stall;
			endcase
		end
	end

	function automatic int unsigned eff_timeout();
		return (timeout_now == 0) ? 1 : timeout_now;
	endfunction

	// ticks that can fall between two bytes without dropping the frame
	function automatic int safe_ticks();
		if (eff_timeout() <= 1)
			return 0;
		return (eff_timeout() - 1 > 3) ? 3 : eff_timeout() - 1;
	endfunction

	function automatic logic [7:0] pick_blank();
		if ($urandom_range(0, 5) != 0)
			return CH_SPACE;
		return 8'($urandom_range(CH_TAB, CH_CR));
	endfunction

	function automatic logic [7:0] frame_lead();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return CH_S;
	endfunction

	// five characters of one reading, first character in the top byte
	function automatic logic [39:0] random_field();
		logic [39:0] f;
		logic [7:0]  ch;
		int          kind, sgn, ndig, nchar, pad, p;
		bit          left;
		f = '0;
		kind = $urandom_range(0, 9);
		sgn = $urandom_range(0, 2);
		ndig = $urandom_range(1, (sgn != 0) ? 4 : 5);
		nchar = ndig + (sgn != 0);
		pad = 5 - nchar;
		left = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < 5; i++) begin
			if (kind < 6) begin
				// number, right aligned behind blanks or left aligned before junk
				p = left ? i : i - pad;
				if (p < 0 || p >= nchar)
					ch = left ? 8'($urandom_range(0, 255)) : pick_blank();
				else if (p == 0 && sgn != 0)
					ch = (sgn == 1) ? CH_MINUS : CH_PLUS;
				else
					ch = 8'(CH_0 + $urandom_range(0, 9));
			end else if (kind < 9) begin
				case ($urandom_range(0, 5))
					0:       ch = pick_blank();
					1:       ch = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
					2, 3:    ch = 8'(CH_0 + $urandom_range(0, 9));
					4:       ch = 8'($urandom_range(8'h3A, 8'h7A));
					default: ch = 8'($urandom_range(0, 255));
				endcase
			end else begin
				ch = 8'($urandom_range(0, 255));
			end
			f[39 - 8 * i -: 8] = ch;
		end
		return f;
	endfunction

	// one input transaction, with bursts and gaps on the sender side
	task automatic push_item(input logic cmd, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1'b1;
		command <= cmd;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++)
			push_item(CMD_TICK, 8'($urandom_range(0, 255)));
	endtask

	// frame bytes 0..upto-1; readings in frame order X, Z, Y
	task automatic send_frame(input logic [7:0] lead, input logic [39:0] fx,
			input logic [39:0] fz, input logic [39:0] fy, input int upto);
		logic [39:0] flds [3];
		logic [7:0]  b;
		int          ci;
		flds[0] = fx;
		flds[1] = fz;
		flds[2] = fy;
		for (int pos = 0; pos < upto; pos++) begin
			ci = (pos - 4) % 8;
			if (pos == 0)
				b = lead;
			else if (pos >= 4 && pos <= 24 && ci < FIELD_CHARS)
				b = flds[(pos - 4) / 8][39 - 8 * ci -: 8];
			else
				b = 8'($urandom_range(0, 255));
			push_item(CMD_BYTE, b);
			if (pos < FRAME_LENGTH - 1 && $urandom_range(0, 7) == 0)
				send_ticks($urandom_range(0, safe_ticks()));
		end
	endtask

	// stop sending and let every due result and any internal work finish
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		wait (results_due == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TIMEOUT)
			timeout_now = value & 16'hFFFF;
		else
			link_now = value[0];
	endtask

	// random traffic: mostly whole frames, some broken frames, noise and ticks
	task automatic run_random(input int n);
		int          stop_at;
		int          pick;
		logic [39:0] fx, fz, fy;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (eff_timeout() > 300 && pick >= 70 && pick < 95)
				pick = 0;
			fx = random_field();
			fz = random_field();
			fy = random_field();
			if (pick < 70) begin
				send_frame(frame_lead(), fx, fz, fy, FRAME_LENGTH);
			end else if (pick < 80) begin
				// partial frame dropped by the silence timer
				send_frame(frame_lead(), fx, fz, fy, $urandom_range(1, FRAME_LENGTH - 1));
				send_ticks(eff_timeout());
			end else if (pick < 88) begin
				// garbage, then resync through a timeout
				repeat ($urandom_range(1, 10))
					push_item($urandom_range(0, 1) ? CMD_TICK : CMD_BYTE,
						8'($urandom_range(0, 255)));
				send_ticks(eff_timeout());
			end else if (pick < 95) begin
				send_ticks($urandom_range(1, eff_timeout() + 2));
			end else begin
				// equal magnitudes and zero readings hit the exact directions
				if ($urandom_range(0, 1))
					fy = fx;
				else
					fz = fy;
				if ($urandom_range(0, 2) == 0)
					fx = "    0";
				send_frame(CH_S, fx, fz, fy, FRAME_LENGTH);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames: zeros, extremes, equal magnitudes, parser corner cases
		send_frame(CH_S, "    0", "    0", "    0", FRAME_LENGTH);
		send_frame(CH_S, "99999", "-9999", "-9999", FRAME_LENGTH);
		send_frame(CH_S, " -250", "  250", "  250", FRAME_LENGTH);
		send_frame(CH_S, "    0", "  -17", "+1234", FRAME_LENGTH);
		send_frame(CH_S, "\t -12", "  +  ", "12x45", FRAME_LENGTH);
		send_frame(CH_S, {8'h0B, 8'h0C, 8'h0A, CH_CR, "7"}, "-a  5", "abcde", FRAME_LENGTH);
		send_frame("s", "  100", "  200", "  300", FRAME_LENGTH);
		// partial frame times out, then the rearmed timer fires again
		send_frame(CH_S, "  111", "  222", "  333", 5);
		send_ticks(eff_timeout());
		send_ticks(eff_timeout());

		// receiver holds off while frames keep coming, so the input backs up
		wait_drained();
		hold_ask <= hold_ask + 1;
		gaps_on = 1'b0;
		repeat (3)
			send_frame(CH_S, random_field(), random_field(), random_field(), FRAME_LENGTH);
		gaps_on = 1'b1;
		wait_drained();

		run_random(200);

		write_reg(CFG_TIMEOUT, 3);
		write_reg(CFG_LINK, 1);
		run_random(180);

		write_reg(CFG_TIMEOUT, 1);
		run_random(140);

		write_reg(CFG_TIMEOUT, 0);
		run_random(110);

		write_reg(CFG_TIMEOUT, 7);
		write_reg(CFG_LINK, 0);
		run_random(180);

		write_reg(CFG_TIMEOUT, 200);
		write_reg(CFG_LINK, 1);
		run_random(140);

		// longest timeout: whole frames only
		write_reg(CFG_TIMEOUT, 65535);
		run_random(80);

		write_reg(CFG_TIMEOUT, 2);
		write_reg(CFG_LINK, 0);
		run_random(140);

		write_reg(CFG_TIMEOUT, 50);
		write_reg(CFG_LINK, 1);
		run_random(140);

		wait_drained();
		if (mismatches == 0)
			$display("** magnetometer_frame_heading: PASSED **");
		else
			$display("** magnetometer_frame_heading: FAILED **");
		$finish;
	end

endmodule
